@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/stb_pkg.sv @@
// Shared constants and types of the segment tile binner.
`default_nettype none
package stb_pkg;
  localparam int TREE_DEPTH = 6;
  localparam int COORD_BITS = 16;
  localparam int TAG_W      = 32;
  localparam int LEAF_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int LVL_W      = $clog2(TREE_DEPTH + 1);
  localparam int SP_W       = $clog2(TREE_DEPTH + 1);
  localparam int STK_AW     = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
  localparam int NUM_W      = 2 * COORD_BITS + 2;
  localparam int CNT_W      = $clog2(NUM_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } piece_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } rect_t;

  typedef struct packed {
    piece_t                pc;
    rect_t                 bnd;
    logic [LVL_W-1:0]      lvl;
    logic [TREE_DEPTH-1:0] path;
  } frame_t;

  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic mul;
    logic div;
    logic cut;
    logic emit;
    logic pop;
  } dp_cmd_t;

  typedef struct packed {
    logic keep;
    logic leaf;
    logic straddle;
    logic div_last;
    logic stk_empty;
    logic out_free;
  } dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/segment_tile_binner.sv @@
// Top level of the segment tile binner: controller plus datapath.
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o   x_start, y_start, x_end, y_end, tag
//   out      out  out_valid_o/out_stall_i leaf_index, piece_*, piece_tag, last
//   cfg      in   cfg_we_i                cfg_idx_i, cfg_data_i
// One segment is worked at a time: it is accepted, descends one tree level per
// step, and each cut runs prep, multiply, the bit-serial restoring divider and
// then the cut itself. Each piece is then loaded into the output register.
// Reset is asynchronous active low; no clearing pass. A held output beat stalls
// only the emit step, and input stays stalled until the last piece is emitted.
`default_nettype none
module segment_tile_binner (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [stb_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] x_start_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] y_start_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] x_end_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] y_end_i,
  input  wire logic [stb_pkg::TAG_W-1:0]             tag_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [stb_pkg::LEAF_W-1:0]                 leaf_index_o,
  output logic signed [stb_pkg::COORD_BITS-1:0]      piece_x1_o,
  output logic signed [stb_pkg::COORD_BITS-1:0]      piece_y1_o,
  output logic signed [stb_pkg::COORD_BITS-1:0]      piece_x2_o,
  output logic signed [stb_pkg::COORD_BITS-1:0]      piece_y2_o,
  output logic [stb_pkg::TAG_W-1:0]                  piece_tag_o,
  output logic                                       last_o
);
  import stb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  stb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .tag_i        (tag_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .leaf_index_o (leaf_index_o),
    .piece_x1_o   (piece_x1_o),
    .piece_y1_o   (piece_y1_o),
    .piece_x2_o   (piece_x2_o),
    .piece_y2_o   (piece_y2_o),
    .piece_tag_o  (piece_tag_o),
    .last_o       (last_o)
  );
endmodule
`default_nettype wire

@@ rtl/stb_ctrl.sv @@
// Sequencer for segment descent, cut division and piece emission.
`default_nettype none
module stb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire stb_pkg::dp_sts_t  sts_i,
  output stb_pkg::dp_cmd_t       cmd_o
);
  import stb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CUT  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.keep) state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.leaf) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            if (sts_i.stk_empty) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.pop = 1'b1;
            end
          end
        end else if (sts_i.straddle) begin
          cmd_o.prep = 1'b1;
          state_d    = S_MUL;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) state_d = S_CUT;
      end
      S_CUT: begin
        cmd_o.cut = 1'b1;
        state_d   = S_EVAL;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/stb_datapath.sv @@
// Piece registers, split stack, serial cut divider and output register.
`default_nettype none
`include "assert_macros.svh"
module stb_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [stb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] cfg_data_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] x_start_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] y_start_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] x_end_i,
  input  wire logic signed [stb_pkg::COORD_BITS-1:0] y_end_i,
  input  wire logic [stb_pkg::TAG_W-1:0]           tag_i,
  input  wire stb_pkg::dp_cmd_t                    cmd_i,
  output stb_pkg::dp_sts_t                         sts_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [stb_pkg::LEAF_W-1:0]               leaf_index_o,
  output logic signed [stb_pkg::COORD_BITS-1:0]    piece_x1_o,
  output logic signed [stb_pkg::COORD_BITS-1:0]    piece_y1_o,
  output logic signed [stb_pkg::COORD_BITS-1:0]    piece_x2_o,
  output logic signed [stb_pkg::COORD_BITS-1:0]    piece_y2_o,
  output logic [stb_pkg::TAG_W-1:0]                piece_tag_o,
  output logic                                     last_o
);
  import stb_pkg::*;

  localparam int W1 = COORD_BITS + 1;

  rect_t                  cfg_q;
  frame_t                 cur_q;
  frame_t                 stk_q [TREE_DEPTH];
  logic [SP_W-1:0]        sp_q;
  logic [SP_W-1:0]        sp_m1;
  logic [TAG_W-1:0]       tag_q;
  coord_t                 split_q;
  logic [COORD_BITS-1:0]  a_q;
  logic [W1-1:0]          babs_q;
  logic [COORD_BITS-1:0]  c_q;
  logic                   neg_q;
  logic [NUM_W-1:0]       num_q;
  logic [COORD_BITS:0]    rem_q;
  logic [W1-1:0]          qt_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   out_valid_q;
  piece_t                 out_pc_q;
  logic [TREE_DEPTH-1:0]  out_path_q;
  logic                   out_last_q;
  logic [TAG_W-1:0]       out_tag_q;

  logic                   axis_y;
  coord_t                 n1, n2, near_n, far_n, near_m, far_m, lo_b, hi_b, split, spl, cut;
  piece_t                 s, pc_lo, pc_hi;
  logic [W1-1:0]          sum, sum_adj, a_w, b_w, c_w, cut_w;
  frame_t                 fr_lo, fr_hi;
  logic                   go_lo, go_hi;
  logic [2*COORD_BITS:0]  prod;
  logic [COORD_BITS+1:0]  rem_sh;
  logic [COORD_BITS+1:0]  rem_dif;
  logic                   q_bit;
  logic                   push;

  assign axis_y = cur_q.lvl[0];
  assign n1 = axis_y ? cur_q.pc.y1 : cur_q.pc.x1;
  assign n2 = axis_y ? cur_q.pc.y2 : cur_q.pc.x2;
  assign s  = (n1 > n2) ? {cur_q.pc.x2, cur_q.pc.y2, cur_q.pc.x1, cur_q.pc.y1} : cur_q.pc;

  assign near_n = axis_y ? s.y1 : s.x1;
  assign far_n  = axis_y ? s.y2 : s.x2;
  assign near_m = axis_y ? s.x1 : s.y1;
  assign far_m  = axis_y ? s.x2 : s.y2;
  assign lo_b   = axis_y ? cur_q.bnd.t : cur_q.bnd.l;
  assign hi_b   = axis_y ? cur_q.bnd.b : cur_q.bnd.r;

  assign sum     = {lo_b[COORD_BITS-1], lo_b} + {hi_b[COORD_BITS-1], hi_b};
  assign sum_adj = sum + W1'(sum[COORD_BITS]);
  assign split   = coord_t'(sum_adj[COORD_BITS:1]);

  assign go_lo = (far_n < split);
  assign go_hi = (near_n >= split);

  assign a_w = {far_n[COORD_BITS-1], far_n} - {split[COORD_BITS-1], split};
  assign b_w = {far_m[COORD_BITS-1], far_m} - {near_m[COORD_BITS-1], near_m};
  assign c_w = {far_n[COORD_BITS-1], far_n} - {near_n[COORD_BITS-1], near_n};

  assign prod = a_q * babs_q;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, c_q, 1'b0};
  assign q_bit   = (rem_sh >= {1'b0, c_q, 1'b0});

  assign cut_w = neg_q ? ({far_m[COORD_BITS-1], far_m} + qt_q)
                       : ({far_m[COORD_BITS-1], far_m} - qt_q);
  assign cut   = coord_t'(cut_w[COORD_BITS-1:0]);

  assign spl   = cmd_i.cut ? split_q : split;
  assign pc_lo = cmd_i.cut ? (axis_y ? {s.x1, s.y1, cut, split_q} : {s.x1, s.y1, split_q, cut}) : s;
  assign pc_hi = cmd_i.cut ? (axis_y ? {cut, split_q, s.x2, s.y2} : {split_q, cut, s.x2, s.y2}) : s;

  always_comb begin
    fr_lo      = cur_q;
    fr_lo.pc   = pc_lo;
    fr_lo.lvl  = cur_q.lvl + LVL_W'(1);
    fr_lo.path = {cur_q.path[TREE_DEPTH-2:0], 1'b0};
    fr_hi      = fr_lo;
    fr_hi.pc   = pc_hi;
    fr_hi.path = {cur_q.path[TREE_DEPTH-2:0], 1'b1};
    if (axis_y) begin
      fr_lo.bnd.b = spl;
      fr_hi.bnd.t = spl;
    end else begin
      fr_lo.bnd.r = spl;
      fr_hi.bnd.l = spl;
    end
  end

  assign push  = cmd_i.cut;
  assign sp_m1 = sp_q - SP_W'(1);

  assign sts_o.keep = !((x_start_i < cfg_q.l) && (x_end_i < cfg_q.l))
                   && !((x_start_i > cfg_q.r) && (x_end_i > cfg_q.r))
                   && !((y_start_i < cfg_q.t) && (y_end_i < cfg_q.t))
                   && !((y_start_i > cfg_q.b) && (y_end_i > cfg_q.b));
  assign sts_o.leaf      = (cur_q.lvl == LVL_W'(TREE_DEPTH));
  assign sts_o.straddle  = !go_lo && !go_hi;
  assign sts_o.div_last  = (cnt_q == CNT_W'(NUM_W - 1));
  assign sts_o.stk_empty = (sp_q == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.l <= '0;
      cfg_q.t <= '0;
      cfg_q.r <= coord_t'(1023);
      cfg_q.b <= coord_t'(1023);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEFT:   cfg_q.l <= cfg_data_i;
        CFG_TOP:    cfg_q.t <= cfg_data_i;
        CFG_RIGHT:  cfg_q.r <= cfg_data_i;
        CFG_BOTTOM: cfg_q.b <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        sp_q <= '0;
      end else if (push) begin
        sp_q <= sp_q + SP_W'(1);
      end else if (cmd_i.pop) begin
        sp_q <= sp_m1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q.pc   <= {x_start_i, y_start_i, x_end_i, y_end_i};
      cur_q.bnd  <= cfg_q;
      cur_q.lvl  <= '0;
      cur_q.path <= '0;
      tag_q      <= tag_i;
    end else if (cmd_i.step) begin
      cur_q <= go_lo ? fr_lo : fr_hi;
    end else if (cmd_i.prep) begin
      cur_q.pc <= s;
    end else if (cmd_i.cut) begin
      cur_q <= fr_lo;
    end else if (cmd_i.pop) begin
      cur_q <= stk_q[sp_m1[STK_AW-1:0]];
    end
    if (push) begin
      stk_q[sp_q[STK_AW-1:0]] <= fr_hi;
    end
    if (cmd_i.prep) begin
      split_q <= split;
      a_q     <= a_w[COORD_BITS-1:0];
      babs_q  <= b_w[COORD_BITS] ? (W1'(0) - b_w) : b_w;
      neg_q   <= b_w[COORD_BITS];
      c_q     <= c_w[COORD_BITS-1:0];
    end
    if (cmd_i.mul) begin
      num_q <= NUM_W'({prod, 1'b0}) + NUM_W'(c_q);
      rem_q <= '0;
      qt_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= q_bit ? rem_dif[COORD_BITS:0] : rem_sh[COORD_BITS:0];
      qt_q  <= {qt_q[W1-2:0], q_bit};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.emit) begin
      out_pc_q   <= s;
      out_path_q <= cur_q.path;
      out_last_q <= (sp_q == '0);
      out_tag_q  <= tag_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign leaf_index_o = LEAF_W'(out_path_q);
  assign piece_x1_o   = out_pc_q.x1;
  assign piece_y1_o   = out_pc_q.y1;
  assign piece_x2_o   = out_pc_q.x2;
  assign piece_y2_o   = out_pc_q.y2;
  assign piece_tag_o  = out_tag_q;
  assign last_o       = out_last_q;

  `ASSERT_NEVER(a_stk_over, clk_i, rst_ni, push && (sp_q >= SP_W'(TREE_DEPTH)), "stack overflow")
  `ASSERT_NEVER(a_stk_under, clk_i, rst_ni, cmd_i.pop && (sp_q == '0), "stack underflow")
  `ASSERT_NEVER(a_emit_busy, clk_i, rst_ni, cmd_i.emit && out_valid_q && out_stall_i, "emit over held beat")
  `ASSERT_CLK(a_lvl_range, clk_i, rst_ni, cmd_i.step |=> (cur_q.lvl <= LVL_W'(TREE_DEPTH)), "level past leaf")
endmodule
`default_nettype wire
